// File: hdl/hslrgb_pkg.sv
// Shared types, constants and helpers for the HSL to RGB pixel unit.
// No dependencies; hslrgb_ramp_arg and the top level in hdl/ refer to this package.
package hslrgb_pkg;

	// Unsigned fixed point, 16 fractional bits.
	localparam int unsigned QW        = 17;          // holds 0..1.0 inclusive
	localparam logic [QW-1:0] Q_ONE   = 17'd65536;
	localparam logic [QW-1:0] Q_HALF  = 17'd32768;
	localparam logic [QW-1:0] Q_THIRD = 17'd21845;
	localparam logic [QW-1:0] Q_TWO_THIRDS = 17'd43690;

	// Piece of the hue ramp that a channel falls on.
	typedef enum logic [1:0] {
		SEG_UP,     // lo + d * 6vh
		SEG_HI,     // hi
		SEG_DOWN,   // lo + d * 6(2/3 - vh)
		SEG_LO      // lo
	} ramp_seg_t;

	typedef struct packed {
		ramp_seg_t   seg;
		logic [15:0] op;    // multiplier operand, a fraction below 1.0
	} ramp_arg_t;

	// Scale a 0..1.0 fraction by 255, round half up, saturate.
	function automatic logic [7:0] to_byte(input logic [QW-1:0] c);
		logic [24:0] t;
		logic [8:0]  v;
		t = ({8'd0, c} << 8) - {8'd0, c} + 25'd32768;
		v = t[24:16];
		return (v > 9'd255) ? 8'hFF : v[7:0];
	endfunction

endpackage

// File: hdl/hslrgb_pix_if.sv
// Input channel of the HSL to RGB unit: one HSL pixel per transfer.
// Standalone interface; no package needed.
interface hslrgb_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] hue_in;
	logic [7:0] sat_in;
	logic [7:0] light_in;

	modport source(output valid, hue_in, sat_in, light_in, input ready);
	modport sink(input valid, hue_in, sat_in, light_in, output ready);
endinterface

// File: hdl/hslrgb_rgb_if.sv
// Output channel of the HSL to RGB unit: one RGB pixel per transfer.
// Standalone interface; no package needed.
interface hslrgb_rgb_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;

	modport source(output valid, red_out, green_out, blue_out, input ready);
	modport sink(input valid, red_out, green_out, blue_out, output ready);
endinterface

// File: hdl/hslrgb_ramp_arg.sv
// Hue ramp segment decode for one channel: takes the wrapped ramp argument
// and picks the segment plus multiplier operand. Uses hslrgb_pkg.
module hslrgb_ramp_arg (
	input  logic [hslrgb_pkg::QW-1:0] vh,
	output hslrgb_pkg::ramp_arg_t     arg
);

	logic [19:0] six_vh;
	logic [18:0] three_vh;
	logic [16:0] down_d;
	logic [19:0] six_down;

	always_comb begin
		six_vh   = {3'd0, vh} * 20'd6;
		three_vh = {2'd0, vh} * 19'd3;
		down_d   = hslrgb_pkg::Q_TWO_THIRDS - vh;
		six_down = {3'd0, down_d} * 20'd6;
		arg.op   = '0;
		if (six_vh < 20'd65536) begin
			arg.seg = hslrgb_pkg::SEG_UP;
			arg.op  = six_vh[15:0];
		end else if (vh < hslrgb_pkg::Q_HALF) begin
			arg.seg = hslrgb_pkg::SEG_HI;
		end else if (three_vh < 19'd131072) begin
			// vh <= 2/3 here, so the operand stays below 1.0
			arg.seg = hslrgb_pkg::SEG_DOWN;
			arg.op  = six_down[15:0];
		end else begin
			arg.seg = hslrgb_pkg::SEG_LO;
		end
	end

endmodule

// File: hdl/hsl_to_rgb_pixel_unit.sv
// HSL to RGB pixel converter, five-stage pipeline, top level.
// Depends on hslrgb_pkg, hslrgb_pix_if, hslrgb_rgb_if, hslrgb_ramp_arg.
//
//  channel | modport | transfer moves
//  --------+---------+---------------------------------------------
//  hsl     | sink    | hue_in, sat_in, light_in (0..HSL_SCALE each)
//  rgb     | source  | red_out, green_out, blue_out (0..255 each)
//
// One pixel per clock sustained while rgb does not stall; an hsl transfer reaches
// rgb valid through the stage chain (lookup, chroma product, chroma levels,
// ramp product, byte rounding).
// arst_n clears only the stage valid bits; payload registers are not reset.
// Each stage advances when it is empty or the stage after it advances, so a
// stall on rgb fills bubbles first and hsl.ready drops only once stage 1 holds.
module hsl_to_rgb_pixel_unit #(
	parameter int HSL_SCALE = 240   // input code for 1.0, range 16..1023
) (
	input  logic         clk,
	input  logic         arst_n,
	hslrgb_pix_if.sink   hsl,
	hslrgb_rgb_if.source rgb
);

	localparam int QW = hslrgb_pkg::QW;

	// ------------------------------------------------------------------
	// Input code -> Q16 fraction tables, built at elaboration.
	// Hue wraps modulo a full turn; sat/light clamp at 1.0.
	// ------------------------------------------------------------------
	function automatic logic [255:0][15:0] build_hue_tab();
		logic [255:0][15:0] t;
		int r;
		for (int i = 0; i < 256; i++) begin
			r    = i % HSL_SCALE;
			t[i] = 16'((r * 65536) / HSL_SCALE);
		end
		return t;
	endfunction

	function automatic logic [255:0][QW-1:0] build_lvl_tab();
		logic [255:0][QW-1:0] t;
		int v;
		for (int i = 0; i < 256; i++) begin
			v    = (i > HSL_SCALE) ? HSL_SCALE : i;
			t[i] = QW'((v * 65536) / HSL_SCALE);
		end
		return t;
	endfunction

	localparam logic [255:0][15:0]    HUE_TAB = build_hue_tab();
	localparam logic [255:0][QW-1:0]  LVL_TAB = build_lvl_tab();

	// ------------------------------------------------------------------
	// Stage flow control
	// ------------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic en1, en2, en3, en4, en5;

	assign en5 = ~vld_s5 | rgb.ready;
	assign en4 = ~vld_s4 | en5;
	assign en3 = ~vld_s3 | en4;
	assign en2 = ~vld_s2 | en3;
	assign en1 = ~vld_s1 | en2;

	assign hsl.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= hsl.valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: table lookups
	// ------------------------------------------------------------------
	logic [15:0]   h_s1;
	logic [QW-1:0] s_s1, l_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			h_s1 <= HUE_TAB[hsl.hue_in];
			s_s1 <= LVL_TAB[hsl.sat_in];
			l_s1 <= LVL_TAB[hsl.light_in];
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: l*s product, ramp arguments at hue+1/3, hue, hue-1/3
	// ------------------------------------------------------------------
	logic [2*QW-1:0] ls_prod;
	logic [QW-1:0]   vh_red, vh_grn, vh_blu, vh_sum;
	hslrgb_pkg::ramp_arg_t arg_red, arg_grn, arg_blu;

	always_comb begin
		ls_prod = l_s1 * s_s1;
		vh_sum  = {1'b0, h_s1} + hslrgb_pkg::Q_THIRD;
		vh_red  = (vh_sum > hslrgb_pkg::Q_ONE) ? vh_sum - hslrgb_pkg::Q_ONE : vh_sum;
		vh_grn  = {1'b0, h_s1};
		// below 1/3 the wrap adds a full turn
		vh_blu  = ({1'b0, h_s1} < hslrgb_pkg::Q_THIRD)
			? {1'b0, h_s1} + hslrgb_pkg::Q_ONE - hslrgb_pkg::Q_THIRD
			: {1'b0, h_s1} - hslrgb_pkg::Q_THIRD;
	end

	hslrgb_ramp_arg u_arg_red (.vh(vh_red), .arg(arg_red));
	hslrgb_ramp_arg u_arg_grn (.vh(vh_grn), .arg(arg_grn));
	hslrgb_ramp_arg u_arg_blu (.vh(vh_blu), .arg(arg_blu));

	logic [QW-1:0] p_s2, s_s2, l_s2;
	logic          gray_s2;
	hslrgb_pkg::ramp_arg_t arg_s2 [3];

	always_ff @(posedge clk) begin
		if (en2) begin
			p_s2      <= ls_prod[QW+15:16];
			s_s2      <= s_s1;
			l_s2      <= l_s1;
			gray_s2   <= (s_s1 == '0);
			arg_s2[0] <= arg_red;
			arg_s2[1] <= arg_grn;
			arg_s2[2] <= arg_blu;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: chroma levels hi and lo
	// ------------------------------------------------------------------
	logic [QW:0]     hi_raw;
	logic [QW+1:0]   lo_raw;   // signed view, two extra bits
	logic [QW-1:0]   lo_cl, hi_cl;

	always_comb begin
		if (l_s2 < hslrgb_pkg::Q_HALF)
			hi_raw = {1'b0, l_s2} + {1'b0, p_s2};
		else
			hi_raw = {1'b0, l_s2} + {1'b0, s_s2} - {1'b0, p_s2};
		lo_raw = {1'b0, l_s2, 1'b0} - {1'b0, hi_raw};
		lo_cl  = lo_raw[QW+1] ? '0 : lo_raw[QW-1:0];
		hi_cl  = (hi_raw < {1'b0, lo_cl}) ? lo_cl : hi_raw[QW-1:0];
	end

	logic [QW-1:0] hi_s3, lo_s3, l_s3;
	logic          gray_s3;
	hslrgb_pkg::ramp_arg_t arg_s3 [3];

	always_ff @(posedge clk) begin
		if (en3) begin
			hi_s3   <= hi_cl;
			lo_s3   <= lo_cl;
			l_s3    <= l_s2;
			gray_s3 <= gray_s2;
			arg_s3  <= arg_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: ramp products (hi - lo) * operand, one per channel
	// ------------------------------------------------------------------
	logic [QW-1:0]    diff;
	logic [QW+15:0]   ramp_prod [3];

	always_comb begin
		diff = hi_s3 - lo_s3;
		for (int c = 0; c < 3; c++)
			ramp_prod[c] = diff * arg_s3[c].op;
	end

	logic [QW-1:0] m_s4 [3];
	logic [QW-1:0] hi_s4, lo_s4, l_s4;
	logic          gray_s4;
	hslrgb_pkg::ramp_seg_t seg_s4 [3];

	always_ff @(posedge clk) begin
		if (en4) begin
			for (int c = 0; c < 3; c++) begin
				m_s4[c]   <= ramp_prod[c][QW+15:16];
				seg_s4[c] <= arg_s3[c].seg;
			end
			hi_s4   <= hi_s3;
			lo_s4   <= lo_s3;
			l_s4    <= l_s3;
			gray_s4 <= gray_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: pick channel level, round to bytes; this is the output reg
	// ------------------------------------------------------------------
	logic [QW-1:0] chan [3];
	logic [7:0]    byte_val [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			case (seg_s4[c])
				hslrgb_pkg::SEG_UP,
				hslrgb_pkg::SEG_DOWN: chan[c] = QW'({1'b0, lo_s4} + {1'b0, m_s4[c]});
				hslrgb_pkg::SEG_HI:   chan[c] = hi_s4;
				hslrgb_pkg::SEG_LO:   chan[c] = lo_s4;
				default:              chan[c] = lo_s4;
			endcase
			byte_val[c] = hslrgb_pkg::to_byte(gray_s4 ? l_s4 : chan[c]);
		end
	end

	logic [7:0] red_s5, grn_s5, blu_s5;
	logic       gray_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			red_s5  <= byte_val[0];
			grn_s5  <= byte_val[1];
			blu_s5  <= byte_val[2];
			gray_s5 <= gray_s4;
		end
	end

	assign rgb.valid     = vld_s5;
	assign rgb.red_out   = red_s5;
	assign rgb.green_out = grn_s5;
	assign rgb.blue_out  = blu_s5;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	// chroma levels stay ordered and within 1.0
	a_levels_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (hi_s3 >= lo_s3 && hi_s3 <= hslrgb_pkg::Q_ONE))
		else $error("chroma levels out of order or above 1.0");

	// zero saturation must come out gray
	a_gray_equal: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 && gray_s5 |-> (red_s5 == grn_s5 && grn_s5 == blu_s5))
		else $error("gray pixel with unequal channels");

	// input backpressure only when the first stage is occupied
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!hsl.ready |-> vld_s1)
		else $error("input stalled with stage 1 empty");

	// a stalled stage 4 item must not be dropped
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && !en4 |=> vld_s4)
		else $error("stage 4 item lost during stall");

endmodule

// File: test/testbench.sv
// Self-checking testbench for hsl_to_rgb_pixel_unit: directed pixels, then random traffic.
// Depends on hslrgb_pkg, hslrgb_pix_if, hslrgb_rgb_if and the unit under test.
module testbench;

	localparam int HSL_SCALE       = 240;
	localparam int PIPE_LATENCY    = 5;
	localparam int ITEMS_PER_PHASE = 110;

	// Fixed-point constants, widened for signed intermediate math.
	localparam longint FRAC_ONE        = longint'(hslrgb_pkg::Q_ONE);
	localparam longint FRAC_HALF       = longint'(hslrgb_pkg::Q_HALF);
	localparam longint FRAC_THIRD      = longint'(hslrgb_pkg::Q_THIRD);
	localparam longint FRAC_TWO_THIRDS = longint'(hslrgb_pkg::Q_TWO_THIRDS);

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_pix_t;

	logic clk = 1'b0;
	logic arst_n;

	int src_idle_pct  = 0;
	int snk_stall_pct = 0;
	int fail_count    = 0;

	rgb_pix_t expected_rgb[$];
	rgb_pix_t want;

	hslrgb_pix_if hsl();
	hslrgb_rgb_if rgb();

	hsl_to_rgb_pixel_unit #(.HSL_SCALE(HSL_SCALE)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.hsl    (hsl),
		.rgb    (rgb)
	);

	always #10 clk = ~clk;

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#(64'd6_000_000);
		$display("[FAIL] regression broken");
		$finish;
	end

	// ---------------- predictor ----------------

	function automatic longint code_to_frac(input int unsigned code);
		return (longint'(code) << 16) / HSL_SCALE;
	endfunction

	function automatic longint frac_mul(input longint a, input longint b);
		return (a * b) >> 16;
	endfunction

	function automatic logic [7:0] frac_to_byte(input longint c);
		longint v;
		if (c < 0)
			c = 0;
		v = (c * 255 + 32768) >> 16;
		return (v > 255) ? 8'hFF : v[7:0];
	endfunction

	// Evaluate the hue ramp at vh, wrapped into 0..1; exactly 1.0 lands on the low level.
	function automatic logic [7:0] ramp_channel(input longint lo, input longint hi,
			input longint vh);
		hslrgb_pkg::ramp_seg_t seg;
		longint    level;
		if (vh < 0)
			vh += FRAC_ONE;
		if (vh > FRAC_ONE)
			vh -= FRAC_ONE;
		if (6 * vh < FRAC_ONE)
			seg = hslrgb_pkg::SEG_UP;
		else if (2 * vh < FRAC_ONE)
			seg = hslrgb_pkg::SEG_HI;
		else if (3 * vh < 2 * FRAC_ONE)
			seg = hslrgb_pkg::SEG_DOWN;
		else
			seg = hslrgb_pkg::SEG_LO;
		case (seg)
			hslrgb_pkg::SEG_UP: begin
				level = lo + frac_mul(hi - lo, 6 * vh);
			end
			hslrgb_pkg::SEG_HI: begin
				level = hi;
			end
			hslrgb_pkg::SEG_DOWN: begin
				level = lo + frac_mul(hi - lo, 6 * (FRAC_TWO_THIRDS - vh));
			end
			default: begin
				level = lo;
			end
		endcase
		return frac_to_byte(level);
	endfunction

	function automatic rgb_pix_t predict_rgb(input logic [7:0] hue, input logic [7:0] sat,
			input logic [7:0] light);
		int unsigned h_code, s_code, l_code;
		longint      h, s, l, hi, lo;
		rgb_pix_t    px;
		// hue wraps by whole turns; saturation and lightness clip at full scale
		h_code = int'(hue) % HSL_SCALE;
		s_code = (int'(sat) > HSL_SCALE) ? HSL_SCALE : int'(sat);
		l_code = (int'(light) > HSL_SCALE) ? HSL_SCALE : int'(light);
		h = code_to_frac(h_code);
		s = code_to_frac(s_code);
		l = code_to_frac(l_code);
		if (s == 0) begin
			px.red   = frac_to_byte(l);
			px.green = px.red;
			px.blue  = px.red;
			return px;
		end
		if (l < FRAC_HALF)
			hi = l + frac_mul(l, s);
		else
			hi = l + s - frac_mul(s, l);
		lo = 2 * l - hi;
		if (lo < 0)
			lo = 0;
		if (hi < lo)
			hi = lo;
		px.red   = ramp_channel(lo, hi, h + FRAC_THIRD);
		px.green = ramp_channel(lo, hi, h);
		px.blue  = ramp_channel(lo, hi, h - FRAC_THIRD);
		return px;
	endfunction

	// ---------------- drivers and checker ----------------

	// One pixel transfer on hsl, with a random idle gap ahead of it.
	task automatic send_pixel(input logic [7:0] hue, input logic [7:0] sat,
			input logic [7:0] light);
		while ($urandom_range(99) < src_idle_pct) begin
			hsl.valid <= 1'b0;
			@(posedge clk);
		end
		hsl.valid    <= 1'b1;
		hsl.hue_in   <= hue;
		hsl.sat_in   <= sat;
		hsl.light_in <= light;
		@(posedge clk);
		while (!hsl.ready)
			@(posedge clk);
		expected_rgb.push_back(predict_rgb(hue, sat, light));
	endtask

	// Hold off the sender until every pending pixel has come out, then let the pipe settle.
	task automatic drain_pipeline();
		hsl.valid <= 1'b0;
		while (expected_rgb.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY) @(posedge clk);
	endtask

	// rgb sink: random back-pressure, compare each transfer with the oldest prediction
	always @(posedge clk) begin
		rgb.ready <= ($urandom_range(99) >= snk_stall_pct);
		if (arst_n === 1'b1 && rgb.valid === 1'b1 && rgb.ready === 1'b1) begin
			if (expected_rgb.size() == 0) begin
				$error("rgb transfer with no pixel pending: %0d %0d %0d",
					rgb.red_out, rgb.green_out, rgb.blue_out);
				fail_count++;
			end else begin
				want = expected_rgb.pop_front();
				if (rgb.red_out !== want.red) begin
					$error("red_out: expected %0d, got %0d", want.red, rgb.red_out);
					fail_count++;
				end
				if (rgb.green_out !== want.green) begin
					$error("green_out: expected %0d, got %0d", want.green, rgb.green_out);
					fail_count++;
				end
				if (rgb.blue_out !== want.blue) begin
					$error("blue_out: expected %0d, got %0d", want.blue, rgb.blue_out);
					fail_count++;
				end
			end
		end
	end

	// ---------------- tests ----------------

	// Zero saturation: gray at black, mid and white, whatever the hue.
	task automatic test_gray_levels();
		send_pixel(8'd0,   8'd0, 8'd0);
		send_pixel(8'd17,  8'd0, 8'd120);
		send_pixel(8'd100, 8'd0, 8'd240);
		send_pixel(8'd255, 8'd0, 8'd255);
	endtask

	// Primaries, secondaries and hue segment boundaries, both chroma formulas.
	task automatic test_hue_ramp();
		send_pixel(8'd0,   8'd240, 8'd120);
		send_pixel(8'd20,  8'd240, 8'd120);
		send_pixel(8'd40,  8'd240, 8'd120);
		send_pixel(8'd60,  8'd240, 8'd60);
		send_pixel(8'd80,  8'd240, 8'd120);
		send_pixel(8'd120, 8'd200, 8'd200);
		send_pixel(8'd140, 8'd1,   8'd119);
		send_pixel(8'd160, 8'd240, 8'd121);
		send_pixel(8'd200, 8'd128, 8'd1);
		send_pixel(8'd239, 8'd240, 8'd239);
	endtask

	// Codes past full scale: hue wraps, saturation and lightness clip.
	task automatic test_out_of_range();
		send_pixel(8'd240, 8'd240, 8'd120);
		send_pixel(8'd250, 8'd241, 8'd120);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd200, 8'd255, 8'd255);
		send_pixel(8'd85,  8'd170, 8'd241);
		send_pixel(8'd128, 8'd255, 8'd170);
	endtask

	// Mostly legal codes, a few zeros and full-scale, some from the whole byte range.
	function automatic logic [7:0] pick_code(input int zero_pct);
		int r;
		r = $urandom_range(99);
		if (r < zero_pct)
			return 8'd0;
		if (r < zero_pct + 5)
			return 8'(HSL_SCALE);
		if (r < zero_pct + 13)
			return 8'($urandom_range(255));
		return 8'($urandom_range(HSL_SCALE));
	endfunction

	// Random pixels through the idle/stall phases, draining between phases.
	task automatic test_random_traffic();
		int idle_set[5]  = '{0, 49, 0, 22, 0};
		int stall_set[5] = '{0, 0, 49, 22, 0};
		for (int ph = 0; ph < 5; ph++) begin
			src_idle_pct  = idle_set[ph];
			snk_stall_pct = stall_set[ph];
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_pixel(pick_code(2), pick_code(4), pick_code(3));
			drain_pipeline();
		end
	endtask

	initial begin
		arst_n       <= 1'b0;
		hsl.valid    <= 1'b0;
		hsl.hue_in   <= 8'd0;
		hsl.sat_in   <= 8'd0;
		hsl.light_in <= 8'd0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_gray_levels();
		test_hue_ramp();
		snk_stall_pct = 30;
		test_out_of_range();
		drain_pipeline();
		test_random_traffic();

		snk_stall_pct = 0;
		repeat (4 * PIPE_LATENCY) @(posedge clk);
		if (fail_count == 0 && expected_rgb.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
